// ===== design/mse_pkg.sv =====
`timescale 1ns / 1ps

package mse_pkg;

  localparam int MEM_BYTES_DEF = 1048576;
  localparam int NUM_REGS      = 32;
  localparam int REG_AW        = 5;
  localparam int DATA_W        = 32;
  localparam int PEW_W         = 19;

  localparam logic [REG_AW-1:0] SP_INDEX = 5'd29;
  localparam logic [DATA_W-1:0] SP_RESET = 32'd1048576;

  typedef enum logic [3:0] {
    REQ_J    = 4'd0,
    REQ_ADDI = 4'd1,
    REQ_ADD  = 4'd2,
    REQ_SUB  = 4'd3,
    REQ_MUL  = 4'd4,
    REQ_SLT  = 4'd5,
    REQ_BEQ  = 4'd6,
    REQ_BNE  = 4'd7,
    REQ_LW   = 4'd8,
    REQ_SW   = 4'd9
  } req_type_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_LABEL     = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_MISALIGN  = 3'd4
  } err_t;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [4:0]  field_rs;
    logic [4:0]  field_rt;
    logic [4:0]  field_rd;
    logic [15:0] imm_raw;
    logic [17:0] target_addr;
    logic        target_known;
  } in_t;

  typedef struct packed {
    logic [2:0]  error_code;
    logic        wr_valid;
    logic [4:0]  wr_reg;
    logic [31:0] wr_value;
    logic        branch_taken;
    logic [17:0] branch_target;
    logic        mem_valid;
    logic        mem_write;
    logic [19:0] mem_address;
    logic [4:0]  mem_reg;
  } out_t;

  // register file write port bundle
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

endpackage

// ===== design/mips_subset_execute_unit.sv =====
`timescale 1ns / 1ps
// execute stage for a small mips integer subset
// input channel in_valid/in_ready/in_data carries one decoded instruction per
// transfer; output channel out_valid/out_ready/out_data carries exactly one
// result per instruction, in order (register write, branch decision, memory
// request or error code)
// cfg_wr_en/cfg_wr_data load the program size in words; write it only while
// the unit is idle
// an instruction taken is held in the input register (stage one) and its
// result is then registered in the output register, which drives out_data
// throughput: one instruction per cycle while out_ready stays high; the limit is
// the register file read, a registered-read ram with a bypass from the previous write
// if the receiver stalls, the result is held and one more instruction may sit
// in the input register; in_ready then drops until the output drains
// reset (rst_n low, synchronous) empties both stages, clears the program size
// and makes the register file read as all zero except register 29, which reads
// as 1048576
module mips_subset_execute_unit #(
  parameter int MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mse_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [18:0]   cfg_wr_data
);
  import mse_pkg::*;

  // stage one: instruction register, operands arrive from the ram alongside
  logic              s1_valid_r;
  in_t               s1_item_r;
  logic [PEW_W-1:0]  prog_end_r;
  logic              out_valid_r;
  out_t              out_r;

  logic              accept, advance;
  logic [DATA_W-1:0] op_a, op_b;
  out_t              exec_res;
  rf_wr_t            rf_wr;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // register file is read as the instruction is taken, written as it retires
  assign rf_wr.en   = advance && exec_res.wr_valid;
  assign rf_wr.addr = exec_res.wr_reg;
  assign rf_wr.data = exec_res.wr_value;

  mse_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_addr_a (in_data.field_rs),
    .rd_addr_b (in_data.field_rt),
    .wr        (rf_wr),
    .rd_data_a (op_a),
    .rd_data_b (op_b)
  );

  mse_exec #(.MEM_BYTES(MEM_BYTES)) u_exec (
    .item           (s1_item_r),
    .op_a           (op_a),
    .op_b           (op_b),
    .prog_end_words (prog_end_r),
    .result         (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prog_end_r  <= '0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        prog_end_r <= cfg_wr_data;
      end
    end
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_r <= exec_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a retiring instruction always lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_r)
    else $error("retired instruction lost");

  // register zero is never reported as written
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.wr_valid |-> out_r.wr_reg != '0)
    else $error("write to register zero reported");

  // a result carries at most one kind of action
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_r.wr_valid, out_r.branch_taken, out_r.mem_valid}))
    else $error("more than one action in a result");

  // an issued memory request is error free and word aligned
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.mem_valid |->
      out_r.error_code == ERR_NONE && out_r.mem_address[1:0] == 2'b00)
    else $error("bad memory request issued");

endmodule

// ===== design/mse_ram.sv =====
`timescale 1ns / 1ps

module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/mse_regfile.sv =====
`timescale 1ns / 1ps

module mse_regfile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [4:0]            rd_addr_a,
  input  logic [4:0]            rd_addr_b,
  input  mse_pkg::rf_wr_t       wr,
  output logic [31:0]           rd_data_a,
  output logic [31:0]           rd_data_b
);
  import mse_pkg::*;

  logic [NUM_REGS-1:0] valid_r;
  logic [REG_AW-1:0]   ra_r, rb_r;
  logic                va_r, vb_r;
  rf_wr_t              last_wr_r;
  logic [DATA_W-1:0]   ram_a, ram_b;

  mse_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
    .clk(clk), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
    .re(rd_en), .raddr(rd_addr_a), .rdata(ram_a)
  );

  mse_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
    .clk(clk), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
    .re(rd_en), .raddr(rd_addr_b), .rdata(ram_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      last_wr_r.en <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
        last_wr_r.en     <= 1'b1;
      end
    end
    if (wr.en) begin
      last_wr_r.addr <= wr.addr;
      last_wr_r.data <= wr.data;
    end
    if (rd_en) begin
      ra_r <= rd_addr_a;
      rb_r <= rd_addr_b;
      va_r <= valid_r[rd_addr_a];
      vb_r <= valid_r[rd_addr_b];
    end
  end

  // most recent write wins over the ram, unwritten entries give reset contents
  function automatic logic [DATA_W-1:0] pick(
    input logic [REG_AW-1:0] addr,
    input logic              vld,
    input logic [DATA_W-1:0] ram,
    input rf_wr_t            lw
  );
    logic [DATA_W-1:0] v;
    if (addr == '0) begin
      v = '0;
    end else if (lw.en && lw.addr == addr) begin
      v = lw.data;
    end else if (vld) begin
      v = ram;
    end else if (addr == SP_INDEX) begin
      v = SP_RESET;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign rd_data_a = pick(ra_r, va_r, ram_a, last_wr_r);
  assign rd_data_b = pick(rb_r, vb_r, ram_b, last_wr_r);

endmodule

// ===== design/mse_exec.sv =====
`timescale 1ns / 1ps

module mse_exec #(
  parameter int MEM_BYTES = mse_pkg::MEM_BYTES_DEF
) (
  input  mse_pkg::in_t        item,
  input  logic [31:0]         op_a,
  input  logic [31:0]         op_b,
  input  logic [18:0]         prog_end_words,
  output mse_pkg::out_t       result
);
  import mse_pkg::*;

  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  logic [32:0]        add_s, sub_s, addi_s, addr_s;
  logic signed [63:0] prod;
  logic [31:0]        imm32, base;
  logic [32:0]        low_bound;
  logic               mul_ovf, lt, eq;
  logic               do_write, is_branch, is_mem, cond, ovf;
  logic [4:0]         dest;
  logic [31:0]        value;

  always_comb begin
    imm32     = {{16{item.imm_raw[15]}}, item.imm_raw};
    add_s     = {op_a[31], op_a} + {op_b[31], op_b};
    sub_s     = {op_a[31], op_a} - {op_b[31], op_b};
    addi_s    = {op_a[31], op_a} + {imm32[31], imm32};
    prod      = $signed(op_a) * $signed(op_b);
    mul_ovf   = prod[63:31] != {33{prod[31]}};
    lt        = $signed(op_a) < $signed(op_b);
    eq        = op_a == op_b;
    base      = (item.req_type == REQ_SW) ? op_b : op_a;
    addr_s    = {base[31], base} + {imm32[31], imm32};
    low_bound = {12'd0, prog_end_words, 2'b00};

    do_write  = 1'b0;
    is_branch = 1'b0;
    is_mem    = 1'b0;
    cond      = 1'b0;
    ovf       = 1'b0;
    dest      = '0;
    value     = '0;

    case (item.req_type)
      REQ_J: begin
        is_branch = 1'b1;
        cond      = 1'b1;
      end
      REQ_ADDI: begin
        do_write = 1'b1;
        dest     = item.field_rt;
        value    = addi_s[31:0];
        ovf      = addi_s[32] != addi_s[31];
      end
      REQ_ADD: begin
        do_write = 1'b1;
        dest     = item.field_rd;
        value    = add_s[31:0];
        ovf      = add_s[32] != add_s[31];
      end
      REQ_SUB: begin
        do_write = 1'b1;
        dest     = item.field_rd;
        value    = sub_s[31:0];
        ovf      = sub_s[32] != sub_s[31];
      end
      REQ_MUL: begin
        do_write = 1'b1;
        dest     = item.field_rd;
        value    = prod[31:0];
        ovf      = mul_ovf;
      end
      REQ_SLT: begin
        do_write = 1'b1;
        dest     = item.field_rd;
        value    = {31'd0, lt};
      end
      REQ_BEQ: begin
        is_branch = 1'b1;
        cond      = eq;
      end
      REQ_BNE: begin
        is_branch = 1'b1;
        cond      = !eq;
      end
      REQ_LW, REQ_SW: begin
        is_mem = 1'b1;
      end
      default: begin
      end
    endcase

    result            = '0;
    result.error_code = ERR_NONE;

    if (do_write) begin
      if (ovf) begin
        result.error_code = ERR_OVERFLOW;
      end else if (dest != '0) begin
        result.wr_valid = 1'b1;
        result.wr_reg   = dest;
        result.wr_value = value;
      end
    end

    if (is_branch) begin
      if (!item.target_known) begin
        result.error_code = ERR_LABEL;
      end else if (cond) begin
        result.branch_taken  = 1'b1;
        result.branch_target = item.target_addr;
      end
    end

    if (is_mem) begin
      // negative, past the end of memory, or inside the program area
      if (addr_s[32] || addr_s >= MEM_LIMIT || addr_s < low_bound) begin
        result.error_code = ERR_RANGE;
      end else if (addr_s[1:0] != 2'b00) begin
        result.error_code = ERR_MISALIGN;
      end else begin
        result.mem_valid   = 1'b1;
        result.mem_write   = item.req_type == REQ_SW;
        result.mem_address = addr_s[19:0];
        result.mem_reg     = (item.req_type == REQ_SW) ? item.field_rs : item.field_rt;
      end
    end
  end

endmodule

// ===== bench/mips_subset_execute_unit_checker.sv =====
`timescale 1ns / 1ps

module mips_subset_execute_unit_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  mse_pkg::in_t              in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  mse_pkg::out_t             out_data,
  input  logic                      cfg_wr_en,
  input  logic [mse_pkg::PEW_W-1:0] cfg_wr_data,
  output int                        fail_count,
  output int                        outstanding,
  output int                        results_seen
);
  import mse_pkg::*;

  logic [DATA_W-1:0] arch_regs [NUM_REGS];
  logic [PEW_W-1:0]  prog_words;
  out_t              retire_q [$];
  out_t              want;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  // architectural effect of one instruction; updates the shadow register file
  function automatic out_t execute_instr(in_t ins);
    out_t       r;
    longint     a, b, imm, val, addr;
    logic       do_wr, is_br, taken, is_mem;
    logic [4:0] dest, mreg;
    r = '0;
    val = 0;
    addr = 0;
    do_wr = 1'b0;
    is_br = 1'b0;
    taken = 1'b0;
    is_mem = 1'b0;
    dest = '0;
    mreg = '0;
    a = (ins.field_rs == '0) ? 0 : longint'($signed(arch_regs[ins.field_rs]));
    b = (ins.field_rt == '0) ? 0 : longint'($signed(arch_regs[ins.field_rt]));
    imm = longint'($signed(ins.imm_raw));
    case (ins.req_type)
      REQ_J: begin
        is_br = 1'b1;
        taken = 1'b1;
      end
      REQ_ADDI: begin
        val = a + imm;
        dest = ins.field_rt;
        do_wr = 1'b1;
      end
      REQ_ADD: begin
        val = a + b;
        dest = ins.field_rd;
        do_wr = 1'b1;
      end
      REQ_SUB: begin
        val = a - b;
        dest = ins.field_rd;
        do_wr = 1'b1;
      end
      REQ_MUL: begin
        val = a * b;
        dest = ins.field_rd;
        do_wr = 1'b1;
      end
      REQ_SLT: begin
        val = (a < b) ? 1 : 0;
        dest = ins.field_rd;
        do_wr = 1'b1;
      end
      REQ_BEQ: begin
        is_br = 1'b1;
        taken = (a == b);
      end
      REQ_BNE: begin
        is_br = 1'b1;
        taken = (a != b);
      end
      REQ_LW: begin
        is_mem = 1'b1;
        addr = a + imm;
        mreg = ins.field_rt;
      end
      REQ_SW: begin
        is_mem = 1'b1;
        addr = b + imm;
        mreg = ins.field_rs;
      end
      default: ;
    endcase

    if (do_wr) begin
      if (val != longint'($signed(val[31:0]))) begin
        r.error_code = ERR_OVERFLOW;
      end else if (dest != '0) begin
        arch_regs[dest] = val[31:0];
        r.wr_valid = 1'b1;
        r.wr_reg = dest;
        r.wr_value = val[31:0];
      end
    end

    if (is_br) begin
      if (!ins.target_known) begin
        r.error_code = ERR_LABEL;
      end else if (taken) begin
        r.branch_taken = 1'b1;
        r.branch_target = ins.target_addr;
      end
    end

    if (is_mem) begin
      if (addr < 0 || addr >= MEM_BYTES_DEF || addr < longint'(prog_words) * 4) begin
        r.error_code = ERR_RANGE;
      end else if (addr[1:0] != 2'b00) begin
        r.error_code = ERR_MISALIGN;
      end else begin
        r.mem_valid = 1'b1;
        r.mem_write = (ins.req_type == REQ_SW);
        r.mem_address = addr[19:0];
        r.mem_reg = mreg;
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (arch_regs[i]) arch_regs[i] = '0;
      arch_regs[SP_INDEX] = SP_RESET;
      prog_words = '0;
      retire_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) prog_words = cfg_wr_data;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (retire_q.size() == 0) begin
          fail_count++;
          $display("%0t: result %0h with nothing expected", $time, out_data);
        end else begin
          want = retire_q.pop_front();
          compare_field("error_code", want.error_code, out_data.error_code);
          compare_field("wr_valid", want.wr_valid, out_data.wr_valid);
          compare_field("wr_reg", want.wr_reg, out_data.wr_reg);
          compare_field("wr_value", want.wr_value, out_data.wr_value);
          compare_field("branch_taken", want.branch_taken, out_data.branch_taken);
          compare_field("branch_target", want.branch_target, out_data.branch_target);
          compare_field("mem_valid", want.mem_valid, out_data.mem_valid);
          compare_field("mem_write", want.mem_write, out_data.mem_write);
          compare_field("mem_address", want.mem_address, out_data.mem_address);
          compare_field("mem_reg", want.mem_reg, out_data.mem_reg);
        end
      end
      if (in_valid && in_ready) retire_q.push_back(execute_instr(in_data));
      outstanding <= retire_q.size();
    end
  end

endmodule

// ===== bench/mips_subset_execute_unit_tb.sv =====
`timescale 1ns / 1ps

module mips_subset_execute_unit_tb;
  import mse_pkg::*;

  // generous bound on the whole run
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RAND_PER_PHASE = 265;
  localparam int NUM_PHASES     = 6;
  // highest request code, unused by the block
  localparam logic [3:0] REQ_CODE_MAX = 4'd15;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_wr_en = 1'b0;
  logic [PEW_W-1:0] cfg_wr_data = '0;

  int   fail_count;
  int   outstanding;
  int   results_seen;
  int   cycle_count = 0;
  int   issued = 0;
  // no idling on either side while set
  logic steady = 1'b0;
  // stack pointer may be overwritten by random traffic
  logic sp_free = 1'b0;

  always #2 clk = ~clk;

  mips_subset_execute_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  mips_subset_execute_unit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  // receiver back-pressure, out_ready low with a chance of 14 in a hundred, never while steady is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic in_t mk_instr(logic [3:0] op, logic [4:0] rs, logic [4:0] rt,
                                   logic [4:0] rd, logic [15:0] imm, logic [17:0] tgt,
                                   logic known);
    in_t ins;
    ins.req_type = op;
    ins.field_rs = rs;
    ins.field_rt = rt;
    ins.field_rd = rd;
    ins.imm_raw = imm;
    ins.target_addr = tgt;
    ins.target_known = known;
    return ins;
  endfunction

  // operand registers lean towards a small working set and the stack pointer
  function automatic logic [4:0] src_reg();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 5'($urandom_range(0, 7));
    if (pick < 75) return SP_INDEX;
    return 5'($urandom);
  endfunction

  // keep the stack pointer intact until the last phase so address
  // sequences stay near the top of memory
  function automatic logic [4:0] dest_reg();
    logic [4:0] r;
    r = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    if (r == SP_INDEX && !sp_free) r = 5'd28;
    return r;
  endfunction

  function automatic logic [15:0] rand_imm();
    case ($urandom_range(0, 2))
      0:       return 16'($urandom_range(0, 16383) * 4);
      1:       return 16'(int'($urandom_range(0, 32)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_instr();
    in_t ins;
    if ($urandom_range(0, 99) < 4)
      ins.req_type = 4'($urandom_range(REQ_SW + 1, REQ_CODE_MAX));
    else
      ins.req_type = 4'($urandom_range(REQ_J, REQ_SW));
    ins.field_rs = src_reg();
    // addi writes its rt field
    ins.field_rt = (ins.req_type == REQ_ADDI) ? dest_reg() : src_reg();
    ins.field_rd = dest_reg();
    ins.imm_raw = rand_imm();
    ins.target_addr = 18'($urandom);
    ins.target_known = ($urandom_range(0, 99) < 90);
    return ins;
  endfunction

  // one transfer on the instruction channel, with an optional idle gap first;
  // returns at the edge on which the transfer happens
  task automatic issue(input in_t ins);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 14) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ins;
    do @(posedge clk); while (!in_ready);
    issued++;
  endtask

  // stop sending and wait until every owed result has been transferred
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_prog_words(input logic [PEW_W-1:0] words);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= words;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // corner cases, run straight after reset with a zero program size
  task automatic run_directed();
    // extreme immediates
    issue(mk_instr(REQ_ADDI, 5'd0, 5'd1, 5'd0, 16'h7FFF, '0, 1'b0));
    issue(mk_instr(REQ_ADDI, 5'd0, 5'd2, 5'd0, 16'h8000, '0, 1'b0));
    // write to register zero is dropped
    issue(mk_instr(REQ_ADDI, 5'd1, 5'd0, 5'd0, 16'd5, '0, 1'b0));
    issue(mk_instr(REQ_ADD, 5'd1, 5'd2, 5'd3, 16'd0, '0, 1'b0));
    issue(mk_instr(REQ_SUB, 5'd2, 5'd1, 5'd4, 16'd0, '0, 1'b0));
    issue(mk_instr(REQ_MUL, 5'd1, 5'd1, 5'd5, 16'd0, '0, 1'b0));
    // r6 lands just below the positive limit, doubling it overflows
    issue(mk_instr(REQ_ADD, 5'd5, 5'd5, 5'd6, 16'd0, '0, 1'b0));
    issue(mk_instr(REQ_ADD, 5'd6, 5'd6, 5'd7, 16'd0, '0, 1'b0));
    issue(mk_instr(REQ_MUL, SP_INDEX, SP_INDEX, 5'd8, 16'd0, '0, 1'b0));
    // near the negative limit, then past it
    issue(mk_instr(REQ_SUB, 5'd2, 5'd6, 5'd9, 16'd0, '0, 1'b0));
    issue(mk_instr(REQ_SUB, 5'd9, 5'd6, 5'd10, 16'd0, '0, 1'b0));
    // signed compare both ways
    issue(mk_instr(REQ_SLT, 5'd2, 5'd1, 5'd11, 16'd0, '0, 1'b0));
    issue(mk_instr(REQ_SLT, 5'd1, 5'd2, 5'd31, 16'd0, '0, 1'b0));
    // branches taken, not taken, and to an undefined label
    issue(mk_instr(REQ_BEQ, 5'd0, 5'd0, 5'd0, 16'd0, 18'h3FFFF, 1'b1));
    issue(mk_instr(REQ_BEQ, 5'd1, 5'd2, 5'd0, 16'd0, 18'h15555, 1'b1));
    issue(mk_instr(REQ_BNE, 5'd1, 5'd2, 5'd0, 16'd0, 18'h00000, 1'b1));
    issue(mk_instr(REQ_J, 5'd0, 5'd0, 5'd0, 16'd0, 18'h2AAAA, 1'b0));
    issue(mk_instr(REQ_BEQ, 5'd0, 5'd0, 5'd0, 16'd0, 18'h3FFFF, 1'b0));
    issue(mk_instr(REQ_J, 5'd31, 5'd31, 5'd31, 16'hFFFF, 18'h2AAAA, 1'b1));
    // top word of memory, one past the end, negative, misaligned, address zero
    issue(mk_instr(REQ_LW, SP_INDEX, 5'd31, 5'd0, 16'hFFFC, '0, 1'b0));
    issue(mk_instr(REQ_LW, SP_INDEX, 5'd13, 5'd0, 16'h0000, '0, 1'b0));
    issue(mk_instr(REQ_SW, 5'd31, 5'd2, 5'd0, 16'h0000, '0, 1'b0));
    issue(mk_instr(REQ_LW, 5'd0, 5'd14, 5'd0, 16'h0002, '0, 1'b0));
    issue(mk_instr(REQ_SW, 5'd31, 5'd0, 5'd0, 16'h0000, '0, 1'b0));
    issue(mk_instr(REQ_LW, 5'd3, 5'd15, 5'd0, 16'h0001, '0, 1'b0));
    issue(mk_instr(REQ_LW, SP_INDEX, 5'd16, 5'd0, 16'h7FFF, '0, 1'b0));
    // unused request code with every field at its maximum
    issue(mk_instr(REQ_CODE_MAX, 5'd31, 5'd31, 5'd31, 16'hFFFF, 18'h3FFFF, 1'b1));
  endtask

  // random traffic; about one in seven steps is a base set-up from the stack
  // pointer followed by a load or store through it
  task automatic run_random(input int count);
    int         done_n;
    logic [4:0] base;
    logic [15:0] offs;
    done_n = 0;
    while (done_n < count) begin
      if ($urandom_range(0, 99) < 15) begin
        base = 5'($urandom_range(1, 7));
        issue(mk_instr(REQ_ADDI, SP_INDEX, base, 5'd0,
                       16'(-int'($urandom_range(0, 8191)) * 4), '0, 1'b1));
        if ($urandom_range(0, 99) < 85)
          offs = 16'($urandom_range(0, 63) * 4);
        else
          offs = 16'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
          issue(mk_instr(REQ_LW, base, src_reg(), dest_reg(), offs, 18'($urandom), 1'b1));
        else
          issue(mk_instr(REQ_SW, src_reg(), base, dest_reg(), offs, 18'($urandom), 1'b1));
        done_n += 2;
      end else begin
        issue(rand_instr());
        done_n++;
      end
    end
  endtask

  initial begin
    logic [PEW_W-1:0] pew_plan [NUM_PHASES];
    // program sizes: none, all of memory, thresholds near the stack top,
    // every low bit set, a small program, and none again
    pew_plan = '{19'd0, 19'd262144, 19'($urandom_range(254000, 262143)),
                 19'd262143, 19'($urandom_range(0, 4096)), 19'd0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      // configuration only changes with the pipeline empty
      if (p > 0) settle();
      steady <= (p == 2);
      sp_free = (p == NUM_PHASES - 1);
      write_prog_words(pew_plan[p]);
      if (p == 0) run_directed();
      run_random(RAND_PER_PHASE);
    end
    settle();
    repeat (4) @(posedge clk);
    $display("summary: %0d instructions sent over %0d program sizes, %0d results compared",
             issued, NUM_PHASES, results_seen);
    $display("summary: corner cases then random streams with stalls on both channels");
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
